>>> design/sprite_frame_sequencer_macros.svh
// assertion macros shared by the sprite frame sequencer modules
`ifndef SPRITE_FRAME_SEQUENCER_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sfs_pkg.sv
// shared types, codes and constants of the sprite frame sequencer
package sfs_pkg;

    localparam int MAX_FRAMES_DEF = 64;

    localparam int TIMER_W = 32;
    localparam int DSR_W   = 32;
    localparam int DVD_W   = 37;
    localparam int STEP_W  = $clog2(DVD_W + 1);
    localparam int FC_W    = 7;

    localparam logic [TIMER_W-1:0] TIMER_MAX  = 32'h7FFF_FFFF;
    localparam logic [TIMER_W-1:0] ONE_SECOND = 32'h0001_0000;
    localparam logic [DVD_W-1:0]   SPEED_NUM  = 37'd25 << 32;

    localparam logic [2:0] MODE_NONE    = 3'd0;
    localparam logic [2:0] MODE_FIRST   = 3'd1;
    localparam logic [2:0] MODE_LAST    = 3'd2;
    localparam logic [2:0] MODE_LOOP    = 3'd3;
    localparam logic [2:0] MODE_REVERSE = 3'd4;
    localparam logic [2:0] MODE_ONCE    = 3'd5;

    localparam logic [1:0] CLASS_SLOW  = 2'd0;
    localparam logic [1:0] CLASS_FAST  = 2'd1;
    localparam logic [1:0] CLASS_SPEED = 2'd2;
    localparam logic [1:0] CLASS_ONE   = 2'd3;

    localparam logic [1:0] REG_SLOW  = 2'd0;
    localparam logic [1:0] REG_FAST  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DSR_W-1:0] remainder;
    } div_res_t;

    function automatic logic [TIMER_W-1:0] sat_timer(input logic [DVD_W-1:0] v);
        logic [TIMER_W-1:0] r;
        begin
            r = (v > DVD_W'(TIMER_MAX)) ? TIMER_MAX : v[TIMER_W-1:0];
            return r;
        end
    endfunction

endpackage

>>> design/sprite_frame_sequencer.sv
// sprite frame sequencer top level: stream ports, register port and item sequencer
//
// One request at a time: the input is not ready from acceptance until the result
// has been handed to the output register. A restart, a forced or static frame and a
// tick that only counts the timer down go from idle straight to the output state. A
// reload of the slow, fast or one-second class also passes through the step state.
// For a nonzero speed, a speed-based reload runs the serial divider, one quotient bit
// per cycle, for 37 steps. A reload in loop or reverse mode then reuses the same
// divider for the wrap remainder, clog2(MAX_FRAMES)+1 steps. A finished result waits
// in the output register while the next request is accepted.
`include "sprite_frame_sequencer_macros.svh"

module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // elapsed[23:0], speed_value[55:24], restart_mode[58:56], new_speed_class[60:59]
    input  logic [63:0] s_tdata,
    // command[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_index[5:0], play_mode[8:6], frame_advanced[9]
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfs_pkg::*;

    localparam int IW    = $clog2(MAX_FRAMES);
    localparam int CW    = $clog2(MAX_FRAMES + 1);
    localparam int MW    = IW + 1;
    localparam int CMP_W = ((CW > FC_W) ? CW : FC_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RELOAD,
        ST_STEP,
        ST_MOD,
        ST_OUT
    } state_t;

    state_t             state_reg;
    logic [31:0]        slow_reg;
    logic [31:0]        fast_reg;
    logic [FC_W-1:0]    count_reg;
    logic [IW-1:0]      idx_reg;
    logic [2:0]         mode_reg;
    logic [1:0]         class_reg;
    logic [TIMER_W-1:0] timer_reg;
    logic               adv_reg;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;
    div_req_t           div_req_reg;
    div_res_t           div_res;

    logic               cmd;
    logic [23:0]        delta;
    logic [31:0]        speed;
    logic [2:0]         nmode;
    logic [1:0]         nclass;
    logic [CMP_W-1:0]   fc_ext;
    logic [CMP_W-1:0]   count_full;
    logic [CW-1:0]      count_c;
    logic               expired;
    logic [TIMER_W-1:0] reload_direct;
    logic [MW-1:0]      mod_val;
    logic               wr_en;

    assign cmd    = s_tuser;
    assign delta  = s_tdata[23:0];
    assign speed  = s_tdata[55:24];
    assign nmode  = s_tdata[58:56];
    assign nclass = s_tdata[60:59];

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        fc_ext     = CMP_W'(count_reg);
        count_full = (fc_ext > CMP_W'(MAX_FRAMES)) ? CMP_W'(MAX_FRAMES) : fc_ext;
        count_c    = CW'(count_full);
        expired    = (timer_reg == '0) || timer_reg[TIMER_W-1];
        case (class_reg)
            CLASS_SLOW: reload_direct = sat_timer(DVD_W'(slow_reg));
            CLASS_FAST: reload_direct = sat_timer(DVD_W'(fast_reg));
            default:    reload_direct = ONE_SECOND;
        endcase
        if (mode_reg == MODE_LOOP)
        begin
            mod_val = MW'(idx_reg) + MW'(1);
        end
        else if (idx_reg == '0)
        begin
            mod_val = MW'(count_c) - MW'(1);
        end
        else
        begin
            mod_val = MW'(idx_reg) - MW'(1);
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SLOW:  prdata = slow_reg;
            REG_FAST:  prdata = fast_reg;
            REG_COUNT: prdata = 32'(count_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_reg  <= 32'd6554;
            fast_reg  <= 32'd2185;
            count_reg <= FC_W'(1);
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_SLOW:  slow_reg  <= pwdata;
                REG_FAST:  fast_reg  <= pwdata;
                REG_COUNT: count_reg <= pwdata[FC_W-1:0];
                default:   ;
            endcase
        end
    end

    sfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .res   (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            mode_reg     <= MODE_NONE;
            class_reg    <= CLASS_SLOW;
            timer_reg    <= '0;
            adv_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            div_req_reg  <= '0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        adv_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                        if (cmd)
                        begin
                            mode_reg  <= nmode;
                            class_reg <= nclass;
                            idx_reg   <= '0;
                        end
                        else if (mode_reg == MODE_NONE || count_full <= CMP_W'(1)
                                 || mode_reg == MODE_FIRST)
                        begin
                            idx_reg <= '0;
                        end
                        else if (mode_reg == MODE_LAST)
                        begin
                            idx_reg <= IW'(count_c - CW'(1));
                        end
                        else if (expired)
                        begin
                            adv_reg <= 1'b1;
                            if (class_reg != CLASS_SPEED)
                            begin
                                timer_reg <= reload_direct;
                                state_reg <= ST_STEP;
                            end
                            else if (speed == '0)
                            begin
                                timer_reg <= TIMER_MAX;
                                state_reg <= ST_STEP;
                            end
                            else
                            begin
                                div_req_reg.start    <= 1'b1;
                                div_req_reg.dividend <= SPEED_NUM;
                                div_req_reg.divisor  <= speed;
                                div_req_reg.steps    <= STEP_W'(DVD_W);
                                state_reg            <= ST_RELOAD;
                            end
                        end
                        else
                        begin
                            timer_reg <= timer_reg - TIMER_W'(delta);
                        end
                    end
                end
                ST_RELOAD:
                begin
                    if (div_res.done)
                    begin
                        timer_reg <= sat_timer(div_res.quotient);
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    state_reg <= ST_OUT;
                    case (mode_reg)
                        MODE_LOOP, MODE_REVERSE:
                        begin
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= {mod_val, {(DVD_W - MW){1'b0}}};
                            div_req_reg.divisor  <= DSR_W'(count_c);
                            div_req_reg.steps    <= STEP_W'(MW);
                            state_reg            <= ST_MOD;
                        end
                        MODE_ONCE:
                        begin
                            if (CMP_W'(idx_reg) + CMP_W'(1) < count_full)
                            begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                            else
                            begin
                                mode_reg <= MODE_LAST;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_MOD:
                begin
                    if (div_res.done)
                    begin
                        idx_reg   <= IW'(div_res.remainder);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b0, adv_reg, mode_reg, 6'(idx_reg)};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SFS_ASSERT_IMPL(a_reload_pos, state_reg == ST_OUT && adv_reg, !timer_reg[TIMER_W-1], "reloaded timer negative")
    `SFS_ASSERT_IMPL(a_wrap_bound, state_reg == ST_MOD && div_res.done, div_res.remainder < DSR_W'(count_c), "wrapped frame out of range")
    `SFS_ASSERT_IMPL(a_adv_mode, m_tvalid_reg && m_tdata_reg[9], m_tdata_reg[8:6] != MODE_NONE && m_tdata_reg[8:6] != MODE_FIRST, "advance reported in static mode")

endmodule

>>> design/sfs_div.sv
// serial restoring divider, one quotient bit per cycle
`include "sprite_frame_sequencer_macros.svh"

module sfs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sfs_pkg::div_req_t req,
    output sfs_pkg::div_res_t res
);
    import sfs_pkg::*;

    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  rem_next;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DSR_W:0]    shifted;
    logic [DSR_W+1:0]  diff;
    logic              ge;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dsr_reg};
        ge       = !diff[DSR_W+1];
        rem_next = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= req.steps;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = dvd_reg;
    assign res.remainder = rem_reg;

    `SFS_ASSERT_IMPL(a_start_idle, req.start, cnt_reg == '0, "divider started while busy")
    `SFS_ASSERT_NEXT(a_start_load, req.start, cnt_reg == $past(req.steps), "step count not loaded")
    `SFS_ASSERT_IMPL(a_rem_bound, cnt_reg != '0, rem_reg < dsr_reg, "partial remainder too large")

endmodule
